// ----- rtl/core/wfpd_pkg.sv -----
// Shared types and constants for the PD wall-following steering block.
// No dependencies; wfpd_cfg, wfpd_div and the top level import it.
package wfpd_pkg;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_BACKUP_FRONT  = 3'd0;
  localparam logic [2:0] REG_EMERG_SIDE    = 3'd1;
  localparam logic [2:0] REG_TURN_FRONT    = 3'd2;
  localparam logic [2:0] REG_TARGET_SIDE   = 3'd3;
  localparam logic [2:0] REG_PROP_GAIN     = 3'd4;
  localparam logic [2:0] REG_DERIV_GAIN    = 3'd5;
  localparam logic [2:0] REG_TURN_LIMIT    = 3'd6;
  localparam logic [2:0] REG_REVERSE_SPEED = 3'd7;

  localparam logic [1:0] MODE_FOLLOW  = 2'd0;
  localparam logic [1:0] MODE_REVERSE = 2'd1;
  localparam logic [1:0] MODE_TURN    = 2'd2;

  localparam logic [10:0] SIDE_CAP_MM    = 11'd1500;
  localparam logic [15:0] DEFAULT_DT_MS  = 16'd20;
  localparam logic [15:0] INVALID_REPORT = 16'hFFFF;
  localparam logic [15:0] TURN_RATE_Q12  = 16'd4915;
  localparam logic signed [16:0] MS_PER_S = 17'sd1000;

  localparam int QUOT_W    = 15;
  localparam int DIV_STEPS = 15;

  typedef struct packed {
    logic [11:0] backup_front_mm;
    logic [11:0] emergency_side_mm;
    logic [11:0] turn_front_mm;
    logic [10:0] target_side_mm;
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
    logic [14:0] turn_limit;
    logic [14:0] reverse_speed;
  } wfpd_cfg_t;

endpackage

// ----- rtl/core/wfpd_cfg.sv -----
// APB-style configuration register file for the steering block.
// Depends on wfpd_pkg.
module wfpd_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wfpd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [wfpd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [wfpd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output wfpd_pkg::wfpd_cfg_t               cfg
);
  import wfpd_pkg::*;

  wfpd_cfg_t   cfg_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.backup_front_mm   <= 12'd130;
      cfg_r.emergency_side_mm <= 12'd80;
      cfg_r.turn_front_mm     <= 12'd200;
      cfg_r.target_side_mm    <= 11'd230;
      cfg_r.prop_gain         <= 16'd393;
      cfg_r.deriv_gain        <= 16'd197;
      cfg_r.turn_limit        <= 15'd6144;
      cfg_r.reverse_speed     <= 15'd410;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BACKUP_FRONT:  cfg_r.backup_front_mm   <= pwdata[11:0];
        REG_EMERG_SIDE:    cfg_r.emergency_side_mm <= pwdata[11:0];
        REG_TURN_FRONT:    cfg_r.turn_front_mm     <= pwdata[11:0];
        REG_TARGET_SIDE:   cfg_r.target_side_mm    <= pwdata[10:0];
        REG_PROP_GAIN:     cfg_r.prop_gain         <= pwdata[15:0];
        REG_DERIV_GAIN:    cfg_r.deriv_gain        <= pwdata[15:0];
        REG_TURN_LIMIT:    cfg_r.turn_limit        <= pwdata[14:0];
        REG_REVERSE_SPEED: cfg_r.reverse_speed     <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BACKUP_FRONT:  prdata = {20'd0, cfg_r.backup_front_mm};
      REG_EMERG_SIDE:    prdata = {20'd0, cfg_r.emergency_side_mm};
      REG_TURN_FRONT:    prdata = {20'd0, cfg_r.turn_front_mm};
      REG_TARGET_SIDE:   prdata = {21'd0, cfg_r.target_side_mm};
      REG_PROP_GAIN:     prdata = {16'd0, cfg_r.prop_gain};
      REG_DERIV_GAIN:    prdata = {16'd0, cfg_r.deriv_gain};
      REG_TURN_LIMIT:    prdata = {17'd0, cfg_r.turn_limit};
      REG_REVERSE_SPEED: prdata = {17'd0, cfg_r.reverse_speed};
      default:           prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/wfpd_mul.sv -----
// Shared signed multiplier with registered product, 30 x 17 bits.
// Depends on nothing beyond the clock.
module wfpd_mul (
  input  logic               clk,
  input  logic signed [29:0] a,
  input  logic signed [16:0] b,
  output logic signed [46:0] prod
);
  logic signed [46:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

// ----- rtl/core/wfpd_div.sv -----
// Restoring divider, one quotient bit per cycle: num / (16 * dt).
// Depends on wfpd_pkg.
module wfpd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [34:0]                   num,
  input  logic [15:0]                   dt,
  output logic                          done,
  output logic [wfpd_pkg::QUOT_W-1:0]   quot
);
  import wfpd_pkg::*;

  logic [34:0]       rem_r;
  logic [33:0]       dsh_r;
  logic [QUOT_W-1:0] quot_r;
  logic [3:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;
  logic [34:0]       rem_sub;

  assign ge      = rem_r >= {1'b0, dsh_r};
  assign rem_sub = rem_r - {1'b0, dsh_r};
  assign done    = done_r;
  assign quot    = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      dsh_r  <= {dt, 18'd0};
      quot_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_sub;
      end
      dsh_r  <= dsh_r >> 1;
      quot_r <= {quot_r[QUOT_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/core/wall_follow_pd_steering_top.sv -----
// Top level of the PD wall-following steering block: sequencer and output stage.
// Depends on wfpd_pkg, wfpd_cfg, wfpd_mul and wfpd_div.
//
//   channel  | handshake                | payload
//   input    | in_valid / in_ready      | in_front_ok, in_front_range, in_side_ok,
//            |                          | in_side_range, in_tick_ms
//   result   | out_valid / out_ready    | out_drive_mode, out_linear_rate,
//            |                          | out_angular_rate, out_front_report, out_side_report
//   config   | psel, penable, pwrite    | paddr, pwdata, prdata, pready
//
// Reverse and turn ticks go from decode straight to the output stage; follow-wall
// ticks take four passes through the shared multiplier, two add stages and a
// 15-step restoring divider, or skip the divider when the PD sum saturates.
// One tick is in flight at a time; in_ready is low until its result is loaded into
// the output register, which then waits for out_ready while the next tick is
// accepted. rst_n is synchronous, clears control state and the last error and sets the
// configuration registers to their defaults.
module wall_follow_pd_steering_top #(
  parameter int CRUISE_SPEED = 614
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_front_ok,
  input  logic [15:0]                       in_front_range,
  input  logic                              in_side_ok,
  input  logic [15:0]                       in_side_range,
  input  logic [15:0]                       in_tick_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_drive_mode,
  output logic signed [15:0]                out_linear_rate,
  output logic signed [15:0]                out_angular_rate,
  output logic [15:0]                       out_front_report,
  output logic [15:0]                       out_side_report,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wfpd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [wfpd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [wfpd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import wfpd_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_DEC  = 10'b00_0000_0010,
    S_MUL1 = 10'b00_0000_0100,
    S_MUL2 = 10'b00_0000_1000,
    S_MUL3 = 10'b00_0001_0000,
    S_MUL4 = 10'b00_0010_0000,
    S_SUM  = 10'b00_0100_0000,
    S_ABS  = 10'b00_1000_0000,
    S_DIV  = 10'b01_0000_0000,
    S_FIN  = 10'b10_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  wfpd_cfg_t         cfg;

  logic              front_ok_r, side_ok_r;
  logic [15:0]       front_range_r, side_range_r, tick_ms_r;
  logic [1:0]        mode_r;
  logic signed [12:0] err_r, prev_error_r;
  logic signed [13:0] diff_r;
  logic [15:0]       dt_r;
  logic signed [46:0] t1_r;
  logic signed [47:0] num_r;
  logic              sign_r, sat_r;

  logic              out_valid_r;
  logic [1:0]        drive_mode_r;
  logic signed [15:0] linear_rate_r, angular_rate_r;
  logic [15:0]       front_report_r, side_report_r;

  logic              in_acc;
  logic              do_reverse, do_turn;
  logic [10:0]       side_lim;
  logic signed [12:0] err_w;
  logic signed [29:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [46:0] prod;
  logic [47:0]       mag_w;
  logic [45:0]       nsum_w;
  logic [45:0]       sat_lim_w;
  logic              div_start, div_done;
  logic [QUOT_W-1:0] quot;
  logic [14:0]       pd_mag;
  logic signed [15:0] ang_w, lin_w;
  logic              fin_go;

  wfpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wfpd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  wfpd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (nsum_w[34:0]),
    .dt    (dt_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid & in_ready;

  assign do_reverse = (front_ok_r && (front_range_r < {4'd0, cfg.backup_front_mm})) ||
                      (side_ok_r && (side_range_r < {4'd0, cfg.emergency_side_mm}));
  assign do_turn    = front_ok_r && (front_range_r < {4'd0, cfg.turn_front_mm});
  assign side_lim   = (side_ok_r && (side_range_r < {5'd0, SIDE_CAP_MM})) ?
                      side_range_r[10:0] : SIDE_CAP_MM;
  assign err_w      = $signed({2'b00, cfg.target_side_mm}) - $signed({2'b00, side_lim});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL1: begin
        mul_a = {{17{err_r[12]}}, err_r};
        mul_b = $signed({1'b0, cfg.prop_gain});
      end
      S_MUL2: begin
        mul_a = prod[29:0];
        mul_b = $signed({1'b0, dt_r});
      end
      S_MUL3: begin
        mul_a = {{16{diff_r[13]}}, diff_r};
        mul_b = $signed({1'b0, cfg.deriv_gain});
      end
      S_MUL4: begin
        mul_a = prod[29:0];
        mul_b = MS_PER_S;
      end
      default: ;
    endcase
  end

  assign mag_w     = num_r[47] ? (48'd0 - num_r) : num_r;
  assign nsum_w    = {1'b0, mag_w[44:0]} + {27'd0, dt_r, 3'd0};
  assign sat_lim_w = {11'd0, dt_r, 19'd0};
  assign div_start = (state_r == S_ABS) && (nsum_w < sat_lim_w);

  assign pd_mag = (sat_r || (quot > cfg.turn_limit)) ? cfg.turn_limit : quot;

  always_comb begin
    case (mode_r)
      MODE_REVERSE: begin
        lin_w = 16'sd0 - $signed({1'b0, cfg.reverse_speed});
        ang_w = '0;
      end
      MODE_TURN: begin
        lin_w = '0;
        ang_w = TURN_RATE_Q12;
      end
      default: begin
        lin_w = 16'(CRUISE_SPEED);
        ang_w = sign_r ? (16'sd0 - $signed({1'b0, pd_mag})) : $signed({1'b0, pd_mag});
      end
    endcase
  end

  assign fin_go = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_DEC;
      S_DEC:  state_nxt = (do_reverse || do_turn) ? S_FIN : S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_MUL3;
      S_MUL3: state_nxt = S_MUL4;
      S_MUL4: state_nxt = S_SUM;
      S_SUM:  state_nxt = S_ABS;
      S_ABS:  state_nxt = div_start ? S_DIV : S_FIN;
      S_DIV:  if (div_done) state_nxt = S_FIN;
      S_FIN:  if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prev_error_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DEC) begin
        prev_error_r <= (do_reverse || do_turn) ? 13'sd0 : err_w;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      front_ok_r    <= in_front_ok;
      front_range_r <= in_front_range;
      side_ok_r     <= in_side_ok;
      side_range_r  <= in_side_range;
      tick_ms_r     <= in_tick_ms;
    end
    if (state_r == S_DEC) begin
      mode_r <= do_reverse ? MODE_REVERSE : (do_turn ? MODE_TURN : MODE_FOLLOW);
      err_r  <= err_w;
      diff_r <= {err_w[12], err_w} - {prev_error_r[12], prev_error_r};
      dt_r   <= (tick_ms_r <= 16'd1) ? DEFAULT_DT_MS : tick_ms_r;
    end
    if (state_r == S_MUL3) begin
      t1_r <= prod;
    end
    if (state_r == S_SUM) begin
      num_r <= {t1_r[46], t1_r} + {prod[46], prod};
    end
    if (state_r == S_ABS) begin
      sign_r <= num_r[47];
      sat_r  <= !div_start;
    end
    if (fin_go) begin
      drive_mode_r   <= mode_r;
      linear_rate_r  <= lin_w;
      angular_rate_r <= ang_w;
      front_report_r <= front_ok_r ? front_range_r : INVALID_REPORT;
      side_report_r  <= side_ok_r ? side_range_r : INVALID_REPORT;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive_mode   = drive_mode_r;
  assign out_linear_rate  = linear_rate_r;
  assign out_angular_rate = angular_rate_r;
  assign out_front_report = front_report_r;
  assign out_side_report  = side_report_r;

endmodule

// ----- test/tb_wall_follow_pd_steering_top.sv -----
// Self-checking testbench for wall_follow_pd_steering_top: drives control ticks and
// APB register writes, predicts each drive command and compares it field by field.
// Depends on wfpd_pkg and the wall_follow_pd_steering_top RTL.
`timescale 1ns / 1ps

module tb_wall_follow_pd_steering_top;
  import wfpd_pkg::*;

  localparam int CRUISE_Q12 = 614;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    logic [15:0]        front;
    logic [15:0]        side;
  } steer_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_front_ok;
  logic [15:0]           in_front_range;
  logic                  in_side_ok;
  logic [15:0]           in_side_range;
  logic [15:0]           in_tick_ms;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_drive_mode;
  logic signed [15:0]    out_linear_rate;
  logic signed [15:0]    out_angular_rate;
  logic [15:0]           out_front_report;
  logic [15:0]           out_side_report;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  wfpd_cfg_t          regs_model;
  logic signed [12:0] last_err;
  steer_cmd_t         pending_cmds[$];
  steer_cmd_t         want;
  int                 errors = 0;
  int                 n_ticks = 0;
  int                 n_reverse = 0;
  int                 n_turn = 0;
  int                 n_follow = 0;
  int                 n_settings = 0;
  bit                 gaps_on = 1'b1;
  bit                 stalls_on = 1'b1;

  always #5 clk = ~clk;

  wall_follow_pd_steering_top #(
    .CRUISE_SPEED(CRUISE_Q12)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_front_ok(in_front_ok),
    .in_front_range(in_front_range),
    .in_side_ok(in_side_ok),
    .in_side_range(in_side_range),
    .in_tick_ms(in_tick_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_drive_mode(out_drive_mode),
    .out_linear_rate(out_linear_rate),
    .out_angular_rate(out_angular_rate),
    .out_front_report(out_front_report),
    .out_side_report(out_side_report),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  function automatic steer_cmd_t predict_command(logic fok, logic [15:0] fr, logic sok,
                                                 logic [15:0] sr, logic [15:0] tms);
    steer_cmd_t c;
    longint     cap;
    longint     side;
    longint     err;
    longint     dt;
    longint     num;
    longint     mag;
    longint     q;
    longint     lim;
    cap = SIDE_CAP_MM;
    c.front = fok ? fr : INVALID_REPORT;
    c.side = sok ? sr : INVALID_REPORT;
    if ((fok && fr < regs_model.backup_front_mm) ||
        (sok && sr < regs_model.emergency_side_mm)) begin
      c.mode = MODE_REVERSE;
      c.lin = 16'(-longint'(regs_model.reverse_speed));
      c.ang = '0;
      last_err = '0;
      n_reverse++;
    end else if (fok && fr < regs_model.turn_front_mm) begin
      c.mode = MODE_TURN;
      c.lin = '0;
      c.ang = TURN_RATE_Q12;
      last_err = '0;
      n_turn++;
    end else begin
      side = sok ? longint'(sr) : cap;
      if (side > cap) side = cap;
      err = longint'(regs_model.target_side_mm) - side;
      dt = (tms <= 1) ? longint'(DEFAULT_DT_MS) : longint'(tms);
      num = longint'(regs_model.prop_gain) * err * dt +
            longint'(regs_model.deriv_gain) * (err - longint'(last_err)) * 1000;
      mag = (num < 0) ? -num : num;
      // round half away from zero, Q0.16 sum rescaled to Q4.12
      q = (mag + dt * 8) / (dt * 16);
      if (num < 0) q = -q;
      lim = longint'(regs_model.turn_limit);
      if (q > lim) q = lim;
      if (q < -lim) q = -lim;
      last_err = 13'(err);
      c.mode = MODE_FOLLOW;
      c.lin = 16'(CRUISE_Q12);
      c.ang = 16'(q);
      n_follow++;
    end
    return c;
  endfunction

  task automatic send_tick(logic fok, logic [15:0] fr, logic sok, logic [15:0] sr,
                           logic [15:0] tms);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        while (!in_ready) @(negedge clk);
      end
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_front_ok    <= fok;
    in_front_range <= fr;
    in_side_ok     <= sok;
    in_side_range  <= sr;
    in_tick_ms     <= tms;
    do @(posedge clk); while (!in_ready);
    pending_cmds.push_back(predict_command(fok, fr, sok, sr, tms));
    n_ticks++;
  endtask

  task automatic drain_ticks();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BACKUP_FRONT:  regs_model.backup_front_mm = value[11:0];
      REG_EMERG_SIDE:    regs_model.emergency_side_mm = value[11:0];
      REG_TURN_FRONT:    regs_model.turn_front_mm = value[11:0];
      REG_TARGET_SIDE:   regs_model.target_side_mm = value[10:0];
      REG_PROP_GAIN:     regs_model.prop_gain = value[15:0];
      REG_DERIV_GAIN:    regs_model.deriv_gain = value[15:0];
      REG_TURN_LIMIT:    regs_model.turn_limit = value[14:0];
      REG_REVERSE_SPEED: regs_model.reverse_speed = value[14:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(wfpd_cfg_t s);
    drain_ticks();
    cfg_write(REG_BACKUP_FRONT, 32'(s.backup_front_mm));
    cfg_write(REG_EMERG_SIDE, 32'(s.emergency_side_mm));
    cfg_write(REG_TURN_FRONT, 32'(s.turn_front_mm));
    cfg_write(REG_TARGET_SIDE, 32'(s.target_side_mm));
    cfg_write(REG_PROP_GAIN, 32'(s.prop_gain));
    cfg_write(REG_DERIV_GAIN, 32'(s.deriv_gain));
    cfg_write(REG_TURN_LIMIT, 32'(s.turn_limit));
    cfg_write(REG_REVERSE_SPEED, 32'(s.reverse_speed));
    n_settings++;
  endtask

  task automatic test_reset_defaults();
    send_tick(1'b1, 16'd0, 1'b1, 16'd230, 16'd20);
    send_tick(1'b1, 16'd129, 1'b1, 16'd500, 16'd20);
    send_tick(1'b1, 16'd130, 1'b1, 16'd500, 16'd20);
    send_tick(1'b1, 16'd199, 1'b1, 16'd79, 16'd20);
    send_tick(1'b1, 16'd500, 1'b1, 16'd80, 16'd20);
    send_tick(1'b1, 16'd199, 1'b1, 16'd300, 16'd20);
    send_tick(1'b0, 16'd0, 1'b0, 16'd0, 16'd0);
    send_tick(1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 16'd1);
    send_tick(1'b1, 16'd200, 1'b1, 16'd1500, 16'd2);
    send_tick(1'b1, 16'd1000, 1'b1, 16'd1501, 16'hFFFF);
    send_tick(1'b1, 16'd1000, 1'b1, 16'd230, 16'd20);
    send_tick(1'b0, 16'd50, 1'b1, 16'd400, 16'hFFFF);
    send_tick(1'b1, 16'd3000, 1'b0, 16'd10, 16'd30);
    send_tick(1'b1, 16'hAAAA, 1'b1, 16'h5555, 16'hAAAA);
    send_tick(1'b0, 16'h5555, 1'b0, 16'hAAAA, 16'h5555);
  endtask

  task automatic test_register_extremes();
    wfpd_cfg_t s;
    apply_settings('0);
    send_tick(1'b1, 16'd0, 1'b1, 16'd0, 16'd20);
    send_tick(1'b0, 16'd0, 1'b1, 16'd1500, 16'd0);
    apply_settings('1);
    send_tick(1'b1, 16'd4094, 1'b1, 16'd5000, 16'd20);
    send_tick(1'b1, 16'd4095, 1'b1, 16'd4094, 16'd20);
    send_tick(1'b1, 16'd4095, 1'b1, 16'd4095, 16'd0);
    send_tick(1'b0, 16'd0, 1'b0, 16'd0, 16'd2);
    s = '1;
    s.backup_front_mm = '0;
    s.emergency_side_mm = '0;
    s.target_side_mm = '0;
    apply_settings(s);
    send_tick(1'b1, 16'd4095, 1'b1, 16'd0, 16'd20);
    send_tick(1'b1, 16'd4094, 1'b1, 16'd0, 16'd20);
    send_tick(1'b1, 16'd5000, 1'b1, 16'd1500, 16'd1);
    send_tick(1'b1, 16'd5000, 1'b1, 16'd0, 16'd3);
  endtask

  task automatic send_random_tick();
    logic        fok;
    logic        sok;
    logic [15:0] fr;
    logic [15:0] sr;
    logic [15:0] tms;
    int          pick;
    int          t;
    fok = ($urandom_range(0, 7) != 0);
    sok = ($urandom_range(0, 7) != 0);
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      fr = 16'($urandom_range(regs_model.turn_front_mm, 4000));
    end else if (pick < 17) begin
      fr = 16'($urandom_range(0, int'(regs_model.turn_front_mm) + 64));
    end else begin
      fr = 16'($urandom);
    end
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      t = int'(regs_model.target_side_mm) + int'($urandom_range(0, 800)) - 400;
      if (t < 0) t = 0;
      sr = 16'(t);
    end else if (pick < 17) begin
      sr = 16'($urandom_range(0, 1700));
    end else begin
      sr = 16'($urandom);
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      tms = 16'($urandom_range(10, 40));
    end else if (pick < 8) begin
      tms = 16'($urandom_range(0, 1));
    end else begin
      tms = 16'($urandom);
    end
    send_tick(fok, fr, sok, sr, tms);
  endtask

  task automatic test_random_phases(int n_phases, int per_phase);
    wfpd_cfg_t s;
    for (int p = 0; p < n_phases; p++) begin
      if (p % 3 == 2) begin
        s = wfpd_cfg_t'({$urandom, $urandom, $urandom, 13'($urandom)});
      end else begin
        s.backup_front_mm = 12'($urandom_range(0, 300));
        s.emergency_side_mm = 12'($urandom_range(0, 200));
        s.turn_front_mm = 12'(int'(s.backup_front_mm) + int'($urandom_range(0, 400)));
        s.target_side_mm = 11'($urandom_range(50, 600));
        s.prop_gain = 16'($urandom_range(0, 4000));
        s.deriv_gain = 16'($urandom_range(0, 4000));
        s.turn_limit = 15'($urandom_range(500, 16000));
        s.reverse_speed = 15'($urandom_range(0, 32767));
      end
      apply_settings(s);
      if (p == n_phases - 1) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      repeat (per_phase) send_random_tick();
    end
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        errors++;
        $error("drive command with no tick pending: mode %0d", out_drive_mode);
      end else begin
        want = pending_cmds.pop_front();
        if (out_drive_mode !== want.mode) begin
          errors++;
          $error("drive_mode expected %0d actual %0d", want.mode, out_drive_mode);
        end
        if (out_linear_rate !== want.lin) begin
          errors++;
          $error("linear_rate expected %0d actual %0d", want.lin, out_linear_rate);
        end
        if (out_angular_rate !== want.ang) begin
          errors++;
          $error("angular_rate expected %0d actual %0d", want.ang, out_angular_rate);
        end
        if (out_front_report !== want.front) begin
          errors++;
          $error("front_report expected %0d actual %0d", want.front, out_front_report);
        end
        if (out_side_report !== want.side) begin
          errors++;
          $error("side_report expected %0d actual %0d", want.side, out_side_report);
        end
      end
    end
  end

  initial begin
    #4ms;
    $display("tb_wall_follow_pd_steering_top NOT OK");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_front_ok    = 1'b0;
    in_front_range = '0;
    in_side_ok     = 1'b0;
    in_side_range  = '0;
    in_tick_ms     = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    regs_model     = '{backup_front_mm: 12'd130, emergency_side_mm: 12'd80,
                       turn_front_mm: 12'd200, target_side_mm: 11'd230,
                       prop_gain: 16'd393, deriv_gain: 16'd197,
                       turn_limit: 15'd6144, reverse_speed: 15'd410};
    last_err       = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_random_phases(7, 135);

    drain_ticks();
    repeat (40) @(posedge clk);
    $display("checked %0d ticks: %0d reverse, %0d turn in place, %0d wall follow",
             n_ticks, n_reverse, n_turn, n_follow);
    $display("register settings applied after reset: %0d", n_settings);
    if (errors == 0) begin
      $display("tb_wall_follow_pd_steering_top OK");
    end else begin
      $display("tb_wall_follow_pd_steering_top NOT OK");
    end
    $finish;
  end

endmodule
